// ----- design/rsi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FORWARD_ONLY = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MISS_COORD   = 4'd1;

    localparam logic [63:0] MISS_INT = 64'd1000;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = 3;
    localparam int CNT_W       = 5;

    // {hit, sign_x, sign_y, d_mag, tn_mag, dx_mag, dy_mag, x1, y1}
    function automatic int entry_width(input int w);
        return 3 + 4 * (w + 1) + 4 * w;
    endfunction

endpackage

`default_nettype wire

// ----- design/rsi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rsi_in_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] wall_ax;
    logic signed [W-1:0] wall_ay;
    logic signed [W-1:0] wall_bx;
    logic signed [W-1:0] wall_by;
    logic signed [W-1:0] ray_ax;
    logic signed [W-1:0] ray_ay;
    logic signed [W-1:0] ray_bx;
    logic signed [W-1:0] ray_by;

    modport source (
        output valid, wall_ax, wall_ay, wall_bx, wall_by, ray_ax, ray_ay, ray_bx, ray_by,
        input  ready
    );
    modport sink (
        input  valid, wall_ax, wall_ay, wall_bx, wall_by, ray_ax, ray_ay, ray_bx, ray_by,
        output ready
    );
endinterface

interface rsi_out_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;

    modport source (output valid, hit, point_x, point_y, input ready);
    modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

interface rsi_cfg_if #(parameter int W = 32) ();
    logic                                valid;
    logic                                ready;
    logic [rsi_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [W-1:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/ray_segment_intersection.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ray against wall segment test in signed fixed point. One item is taken per clock while
// item_in.ready shows room in the queue; each gives one result, hit plus intersection point
// or miss_coord on both axes. A four-stage front forms the determinant and numerators and
// classifies the item, an eight-entry queue holds classified items, and the back scales the
// wall offset and divides by the determinant through a chain of COORD_WIDTH stages, one
// quotient bit each, which sets the latency. Configuration: index 0 forward_only (reset 1),
// index 1 miss_coord (reset 1000.0); write only while idle.
module ray_segment_intersection #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rsi_in_if.sink                item_in,
    rsi_out_if.source             result_out,
    rsi_cfg_if.sink               cfg
);

    localparam int W  = COORD_WIDTH;
    localparam int EW = rsi_pkg::entry_width(W);
    localparam logic [63:0] MISS_FULL = rsi_pkg::MISS_INT << FRAC_BITS;
    localparam logic [W-1:0] MISS_RESET = MISS_FULL[W-1:0];

    logic                      forward_only_reg;
    logic [W-1:0]              miss_coord_reg;
    logic                      push, pop, empty;
    logic [EW-1:0]             push_data, head;
    logic [rsi_pkg::CNT_W-1:0] fifo_count;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_only_reg <= 1'b1;
            miss_coord_reg   <= MISS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rsi_pkg::CFG_FORWARD_ONLY)
            begin
                forward_only_reg <= cfg.data[0];
            end
            else if (cfg.index == rsi_pkg::CFG_MISS_COORD)
            begin
                miss_coord_reg <= cfg.data;
            end
        end
    end

    rsi_front #(.W(W)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_in      (item_in),
        .forward_only (forward_only_reg),
        .fifo_count   (fifo_count),
        .push         (push),
        .push_data    (push_data)
    );

    rsi_fifo #(.WIDTH(EW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty),
        .count     (fifo_count)
    );

    rsi_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .miss_coord (miss_coord_reg),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// ----- design/rsi_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsi_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic [WIDTH-1:0]          push_data,
    input  wire logic                      pop,
    output logic      [WIDTH-1:0]          pop_data,
    output logic                           empty,
    output logic      [rsi_pkg::CNT_W-1:0] count
);

    logic [WIDTH-1:0]            mem [0:rsi_pkg::QUEUE_DEPTH-1];
    logic [rsi_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rsi_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rsi_pkg::CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + rsi_pkg::CNT_W'(push) - rsi_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

`default_nettype wire

// ----- design/rsi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsi_front #(
    parameter int W = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    rsi_in_if.sink                         item_in,
    input  wire logic                      forward_only,
    input  wire logic [rsi_pkg::CNT_W-1:0] fifo_count,
    output logic                           push,
    output logic [rsi_pkg::entry_width(W)-1:0] push_data
);

    localparam int W1 = W + 1;
    localparam int P2 = 2 * W + 2;
    localparam int P3 = 2 * W + 3;
    localparam int DM = 2 * W + 2;

    logic accept;

    // stage 1: differences
    logic                 s1_valid_reg;
    logic signed [W1-1:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_e_reg, s1_f_reg, s1_g_reg;
    logic signed [W1-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [W-1:0]  s1_x1_reg, s1_y1_reg;

    // stage 2: products
    logic                 s2_valid_reg;
    logic signed [P2-1:0] s2_ab_reg, s2_ce_reg, s2_fb_reg, s2_ge_reg, s2_cf_reg, s2_ag_reg;
    logic signed [W1-1:0] s2_dx_reg, s2_dy_reg;
    logic signed [W-1:0]  s2_x1_reg, s2_y1_reg;

    // stage 3: determinant and numerators
    logic                 s3_valid_reg;
    logic signed [P3-1:0] s3_d_reg, s3_tn_reg, s3_un_reg;
    logic signed [W1-1:0] s3_dx_reg, s3_dy_reg;
    logic signed [W-1:0]  s3_x1_reg, s3_y1_reg;

    // stage 4: classified entry
    logic                                s4_valid_reg;
    logic [rsi_pkg::entry_width(W)-1:0]  s4_entry_reg, s4_entry_next;

    logic signed [P2-1:0] ab, ce, fb, ge, cf, ag;
    logic signed [P3-1:0] d_abs, tn_abs;
    logic signed [W1-1:0] dx_abs, dy_abs;
    logic                 d_neg, tn_neg, un_neg, dx_neg, dy_neg;
    logic [DM-1:0]        d_mag, tn_mag;
    logic                 hit;
    logic [rsi_pkg::CNT_W-1:0] in_flight;

    always_comb
    begin
        in_flight = rsi_pkg::CNT_W'(s1_valid_reg) + rsi_pkg::CNT_W'(s2_valid_reg)
                  + rsi_pkg::CNT_W'(s3_valid_reg) + rsi_pkg::CNT_W'(s4_valid_reg);
    end

    assign item_in.ready = (in_flight + fifo_count) < rsi_pkg::CNT_W'(rsi_pkg::QUEUE_DEPTH);
    assign accept        = item_in.valid && item_in.ready;

    assign ab = s1_a_reg * s1_b_reg;
    assign ce = s1_c_reg * s1_e_reg;
    assign fb = s1_f_reg * s1_b_reg;
    assign ge = s1_g_reg * s1_e_reg;
    assign cf = s1_c_reg * s1_f_reg;
    assign ag = s1_a_reg * s1_g_reg;

    always_comb
    begin
        d_neg  = s3_d_reg[P3-1];
        tn_neg = s3_tn_reg[P3-1];
        un_neg = s3_un_reg[P3-1];
        dx_neg = s3_dx_reg[W1-1];
        dy_neg = s3_dy_reg[W1-1];
        d_abs  = d_neg ? -s3_d_reg : s3_d_reg;
        tn_abs = tn_neg ? -s3_tn_reg : s3_tn_reg;
        dx_abs = dx_neg ? -s3_dx_reg : s3_dx_reg;
        dy_abs = dy_neg ? -s3_dy_reg : s3_dy_reg;
        d_mag  = d_abs[DM-1:0];
        tn_mag = tn_abs[DM-1:0];
        hit = (s3_d_reg != '0) && (s3_tn_reg != '0) && (tn_neg == d_neg) && (tn_mag < d_mag);
        if (forward_only && ((s3_un_reg == '0) || (un_neg != d_neg)))
        begin
            hit = 1'b0;
        end
        s4_entry_next = {hit, tn_neg ^ d_neg ^ dx_neg, tn_neg ^ d_neg ^ dy_neg, d_mag, tn_mag,
                         dx_abs[W-1:0], dy_abs[W-1:0], s3_x1_reg, s3_y1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg  <= W1'(item_in.wall_ax) - W1'(item_in.wall_bx);
        s1_b_reg  <= W1'(item_in.ray_ay) - W1'(item_in.ray_by);
        s1_c_reg  <= W1'(item_in.wall_ay) - W1'(item_in.wall_by);
        s1_e_reg  <= W1'(item_in.ray_ax) - W1'(item_in.ray_bx);
        s1_f_reg  <= W1'(item_in.wall_ax) - W1'(item_in.ray_ax);
        s1_g_reg  <= W1'(item_in.wall_ay) - W1'(item_in.ray_ay);
        s1_dx_reg <= W1'(item_in.wall_bx) - W1'(item_in.wall_ax);
        s1_dy_reg <= W1'(item_in.wall_by) - W1'(item_in.wall_ay);
        s1_x1_reg <= item_in.wall_ax;
        s1_y1_reg <= item_in.wall_ay;

        s2_ab_reg <= ab;
        s2_ce_reg <= ce;
        s2_fb_reg <= fb;
        s2_ge_reg <= ge;
        s2_cf_reg <= cf;
        s2_ag_reg <= ag;
        s2_dx_reg <= s1_dx_reg;
        s2_dy_reg <= s1_dy_reg;
        s2_x1_reg <= s1_x1_reg;
        s2_y1_reg <= s1_y1_reg;

        s3_d_reg  <= P3'(s2_ab_reg) - P3'(s2_ce_reg);
        s3_tn_reg <= P3'(s2_fb_reg) - P3'(s2_ge_reg);
        s3_un_reg <= P3'(s2_cf_reg) - P3'(s2_ag_reg);
        s3_dx_reg <= s2_dx_reg;
        s3_dy_reg <= s2_dy_reg;
        s3_x1_reg <= s2_x1_reg;
        s3_y1_reg <= s2_y1_reg;

        s4_entry_reg <= s4_entry_next;
    end

    assign push      = s4_valid_reg;
    assign push_data = s4_entry_reg;

endmodule

`default_nettype wire

// ----- design/rsi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsi_back #(
    parameter int W = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [rsi_pkg::entry_width(W)-1:0] head,
    input  wire logic                               empty,
    output logic                                    pop,
    input  wire logic [W-1:0]                       miss_coord,
    rsi_out_if.source                               result_out
);

    localparam int W1 = W + 1;
    localparam int DM = 2 * W + 2;
    localparam int PP = 2 * W + 1;
    localparam int PW = 3 * W + 2;

    logic              h_hit, h_sx, h_sy;
    logic [DM-1:0]     h_dmag, h_tnm;
    logic [W-1:0]      h_dxm, h_dym;
    logic signed [W-1:0] h_x1, h_y1;

    logic adv;

    // multiply stage
    logic                b1_valid_reg;
    logic                b1_hit_reg, b1_sx_reg, b1_sy_reg;
    logic [DM-1:0]       b1_dmag_reg;
    logic [PP-1:0]       b1_xlo_reg, b1_xhi_reg, b1_ylo_reg, b1_yhi_reg;
    logic signed [W-1:0] b1_x1_reg, b1_y1_reg;

    // divider chain, index 0 holds the full products
    logic                dv_valid_reg [0:W];
    logic                dv_hit_reg   [0:W];
    logic                dv_sx_reg    [0:W];
    logic                dv_sy_reg    [0:W];
    logic [DM-1:0]       dv_dmag_reg  [0:W];
    logic [PW-1:0]       dv_rx_reg    [0:W];
    logic [PW-1:0]       dv_ry_reg    [0:W];
    logic [W-1:0]        dv_qx_reg    [0:W];
    logic [W-1:0]        dv_qy_reg    [0:W];
    logic signed [W-1:0] dv_x1_reg    [0:W];
    logic signed [W-1:0] dv_y1_reg    [0:W];

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [W-1:0]        out_x_reg, out_x_next;
    logic [W-1:0]        out_y_reg, out_y_next;
    logic signed [W1-1:0] qx_s, qy_s, sum_x, sum_y;

    assign {h_hit, h_sx, h_sy, h_dmag, h_tnm, h_dxm, h_dym, h_x1, h_y1} = head;

    assign adv = !out_valid_reg || result_out.ready;
    assign pop = adv && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg    <= pop;
            dv_valid_reg[0] <= b1_valid_reg;
            out_valid_reg   <= dv_valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_hit_reg  <= h_hit;
            b1_sx_reg   <= h_sx;
            b1_sy_reg   <= h_sy;
            b1_dmag_reg <= h_dmag;
            b1_xlo_reg  <= h_tnm[W1-1:0] * h_dxm;
            b1_xhi_reg  <= h_tnm[DM-1:W1] * h_dxm;
            b1_ylo_reg  <= h_tnm[W1-1:0] * h_dym;
            b1_yhi_reg  <= h_tnm[DM-1:W1] * h_dym;
            b1_x1_reg   <= h_x1;
            b1_y1_reg   <= h_y1;

            dv_hit_reg[0]  <= b1_hit_reg;
            dv_sx_reg[0]   <= b1_sx_reg;
            dv_sy_reg[0]   <= b1_sy_reg;
            dv_dmag_reg[0] <= b1_dmag_reg;
            dv_rx_reg[0]   <= PW'(b1_xlo_reg) + (PW'(b1_xhi_reg) << W1);
            dv_ry_reg[0]   <= PW'(b1_ylo_reg) + (PW'(b1_yhi_reg) << W1);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_x1_reg[0]   <= b1_x1_reg;
            dv_y1_reg[0]   <= b1_y1_reg;

            out_hit_reg <= dv_hit_reg[W];
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < W; k++)
    begin : g_div
        localparam int SH = W - 1 - k;
        logic [PW-1:0] dsh;
        logic          ge_x, ge_y;

        assign dsh  = PW'(dv_dmag_reg[k]) << SH;
        assign ge_x = dv_rx_reg[k] >= dsh;
        assign ge_y = dv_ry_reg[k] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_hit_reg[k+1]  <= dv_hit_reg[k];
                dv_sx_reg[k+1]   <= dv_sx_reg[k];
                dv_sy_reg[k+1]   <= dv_sy_reg[k];
                dv_dmag_reg[k+1] <= dv_dmag_reg[k];
                dv_rx_reg[k+1]   <= ge_x ? dv_rx_reg[k] - dsh : dv_rx_reg[k];
                dv_ry_reg[k+1]   <= ge_y ? dv_ry_reg[k] - dsh : dv_ry_reg[k];
                dv_qx_reg[k+1]   <= (dv_qx_reg[k] << 1) | W'(ge_x);
                dv_qy_reg[k+1]   <= (dv_qy_reg[k] << 1) | W'(ge_y);
                dv_x1_reg[k+1]   <= dv_x1_reg[k];
                dv_y1_reg[k+1]   <= dv_y1_reg[k];
            end
        end
    end

    always_comb
    begin
        qx_s  = $signed({1'b0, dv_qx_reg[W]});
        qy_s  = $signed({1'b0, dv_qy_reg[W]});
        sum_x = W1'(dv_x1_reg[W]) + (dv_sx_reg[W] ? -qx_s : qx_s);
        sum_y = W1'(dv_y1_reg[W]) + (dv_sy_reg[W] ? -qy_s : qy_s);
        out_x_next = dv_hit_reg[W] ? sum_x[W-1:0] : miss_coord;
        out_y_next = dv_hit_reg[W] ? sum_y[W-1:0] : miss_coord;
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.hit     = out_hit_reg;
    assign result_out.point_x = out_x_reg;
    assign result_out.point_y = out_y_reg;

endmodule

`default_nettype wire
